/* rtl/mvt_pkg.sv */
// Shared types and constants for the 4x4 fixed-point matrix transform.
`default_nettype none

package mvt_pkg;

   localparam int LANES = 4;
   localparam int ELEM_W = 32;
   localparam int W_LANE = 3;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);

   localparam logic [1:0] REQ_LOAD_ROW = 2'd0;
   localparam logic [1:0] REQ_IDENTITY = 2'd1;
   localparam logic [1:0] REQ_XFORM4 = 2'd2;
   localparam logic [1:0] REQ_XFORM3 = 2'd3;

   localparam logic [ELEM_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
   localparam logic [ELEM_W-1:0] SAT_MIN = 32'h8000_0000;

   typedef enum logic [1:0] {
      OP_LOAD_ROW,
      OP_IDENTITY,
      OP_XFORM4,
      OP_XFORM3
   } op_type;

   typedef struct packed {
      op_type op;
      logic [1:0] row;
      logic row_ok;
      logic [LANES-1:0][ELEM_W-1:0] vec;
   } q_entry_type;

   typedef struct packed {
      logic not_empty;
      logic full;
   } q_stat_type;

endpackage

`default_nettype wire

/* rtl/mvt_front.sv */
// Front end: decodes request items and forms queue entries.
`default_nettype none

module mvt_front import mvt_pkg::*; #(
   parameter int DIM = 4
) (
   input wire logic req_valid,
   output logic req_stall,
   input wire logic [1:0] req_type,
   input wire logic [1:0] req_row_index,
   input wire logic signed [ELEM_W-1:0] req_elem_0,
   input wire logic signed [ELEM_W-1:0] req_elem_1,
   input wire logic signed [ELEM_W-1:0] req_elem_2,
   input wire logic signed [ELEM_W-1:0] req_elem_3,
   input wire q_stat_type qstat,
   output logic push,
   output q_entry_type entry
);

   op_type op;

   always_comb begin
      case (req_type)
         REQ_LOAD_ROW: op = OP_LOAD_ROW;
         REQ_IDENTITY: op = OP_IDENTITY;
         REQ_XFORM4: op = OP_XFORM4;
         REQ_XFORM3: op = OP_XFORM3;
         default: op = OP_XFORM4;
      endcase
   end

   always_comb begin
      entry.op = op;
      entry.row = req_row_index;
      entry.row_ok = (int'(req_row_index) < DIM);
      entry.vec[0] = req_elem_0;
      entry.vec[1] = req_elem_1;
      entry.vec[2] = req_elem_2;
      entry.vec[W_LANE] = (op == OP_XFORM3) ? '0 : req_elem_3;
   end

   assign req_stall = qstat.full;
   assign push = req_valid && !qstat.full;

endmodule

`default_nettype wire

/* rtl/mvt_queue.sv */
// Short item queue between the front end and the arithmetic back end.
`default_nettype none

module mvt_queue import mvt_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   input wire logic push,
   input wire q_entry_type entry,
   input wire logic pop,
   output q_entry_type head,
   output q_stat_type qstat
);

   q_entry_type mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= entry;
      end
   end

   assign head = mem_ff[rd_ptr_ff];
   assign qstat.not_empty = (count_ff != '0);
   assign qstat.full = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QPTR_W+1)'(QUEUE_DEPTH))
      else $error("queue count above depth");

   a_pop_needs_item: assert property (@(posedge clock) disable iff (reset)
      pop |-> qstat.not_empty)
      else $error("pop from empty queue");

   a_last_pop_empties: assert property (@(posedge clock) disable iff (reset)
      (pop && !push && count_ff == (QPTR_W+1)'(1)) |=> !qstat.not_empty)
      else $error("queue not empty after last pop");

endmodule

`default_nettype wire

/* rtl/mvt_back.sv */
// Back end: matrix store and the multiply, truncate, sum and saturate pipeline.
`default_nettype none

module mvt_back import mvt_pkg::*; #(
   parameter int DIM = 4,
   parameter int FRAC_BITS = 16
) (
   input wire logic clock,
   input wire logic reset,
   input wire q_entry_type head,
   input wire q_stat_type qstat,
   output logic pop,
   output logic rsp_valid,
   input wire logic rsp_stall,
   output logic signed [ELEM_W-1:0] rsp_out_x,
   output logic signed [ELEM_W-1:0] rsp_out_y,
   output logic signed [ELEM_W-1:0] rsp_out_z,
   output logic signed [ELEM_W-1:0] rsp_out_w,
   output logic rsp_saturated
);

   localparam int NACT = (DIM < LANES) ? DIM : LANES;
   localparam int PROD_W = 2 * ELEM_W;
   localparam int SUM_W = PROD_W + $clog2(LANES);
   localparam logic [ELEM_W-1:0] ONE = ELEM_W'(64'd1 << FRAC_BITS);
   localparam logic signed [PROD_W-1:0] BIAS = PROD_W'((65'd1 << FRAC_BITS) - 65'd1);

   logic [ELEM_W-1:0] mat_ff [DIM][DIM];
   logic [ELEM_W-1:0] mat_in [DIM][DIM];

   logic pipe_en;
   logic v1_in, v1_ff, v2_ff, v3_ff, rsp_valid_ff;
   logic [LANES-1:0] act_in, act1_ff, act2_ff, act3_ff, act4_ff;

   logic signed [PROD_W-1:0] prod_in [NACT][NACT];
   logic signed [PROD_W-1:0] prod_ff [NACT][NACT];
   logic signed [PROD_W-1:0] trunc_in [NACT][NACT];
   logic signed [PROD_W-1:0] trunc_ff [NACT][NACT];
   logic signed [SUM_W-1:0] sum_in [NACT];
   logic signed [SUM_W-1:0] sum_ff [NACT];
   logic [ELEM_W-1:0] out_in [LANES];
   logic [ELEM_W-1:0] out_ff [LANES];
   logic sat_in, sat_ff;
   logic clip_seen;

   assign pipe_en = !(rsp_valid_ff && rsp_stall);
   assign pop = pipe_en && qstat.not_empty;
   assign v1_in = pop && (head.op == OP_XFORM4 || head.op == OP_XFORM3);

   // Row loads and identity take effect as their item leaves the queue.
   always_comb begin
      mat_in = mat_ff;
      if (pop) begin
         case (head.op)
            OP_LOAD_ROW: begin
               if (head.row_ok) begin
                  for (int r = 0; r < DIM; r++) begin
                     if (int'(head.row) == r) begin
                        for (int c = 0; c < DIM; c++) begin
                           mat_in[r][c] = '0;
                        end
                        for (int c = 0; c < NACT; c++) begin
                           mat_in[r][c] = head.vec[c];
                        end
                     end
                  end
               end
            end
            OP_IDENTITY: begin
               for (int r = 0; r < DIM; r++) begin
                  for (int c = 0; c < DIM; c++) begin
                     mat_in[r][c] = (r == c) ? ONE : '0;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < DIM; r++) begin
            for (int c = 0; c < DIM; c++) begin
               mat_ff[r][c] <= '0;
            end
         end
      end else begin
         mat_ff <= mat_in;
      end
   end

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         act_in[i] = (i < DIM) && !(head.op == OP_XFORM3 && i == W_LANE);
      end
      for (int i = 0; i < NACT; i++) begin
         for (int j = 0; j < NACT; j++) begin
            prod_in[i][j] = PROD_W'($signed(mat_ff[i][j])) * PROD_W'($signed(head.vec[j]));
         end
      end
   end

   // Negative products are biased before the arithmetic shift so they round toward zero.
   always_comb begin
      logic signed [PROD_W-1:0] biased;
      biased = '0;
      for (int i = 0; i < NACT; i++) begin
         for (int j = 0; j < NACT; j++) begin
            if (prod_ff[i][j][PROD_W-1]) begin
               biased = prod_ff[i][j] + BIAS;
            end else begin
               biased = prod_ff[i][j];
            end
            trunc_in[i][j] = biased >>> FRAC_BITS;
         end
      end
   end

   always_comb begin
      logic signed [SUM_W-1:0] acc;
      acc = '0;
      for (int i = 0; i < NACT; i++) begin
         acc = '0;
         for (int j = 0; j < NACT; j++) begin
            acc = acc + SUM_W'(trunc_ff[i][j]);
         end
         sum_in[i] = acc;
      end
   end

   always_comb begin
      logic [SUM_W-ELEM_W:0] upper;
      upper = '0;
      sat_in = 1'b0;
      for (int i = 0; i < LANES; i++) begin
         out_in[i] = '0;
      end
      for (int i = 0; i < NACT; i++) begin
         upper = sum_ff[i][SUM_W-1:ELEM_W-1];
         if (act3_ff[i]) begin
            if ((&upper) || !(|upper)) begin
               out_in[i] = sum_ff[i][ELEM_W-1:0];
            end else begin
               out_in[i] = sum_ff[i][SUM_W-1] ? SAT_MIN : SAT_MAX;
               sat_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         v1_ff <= v1_in;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         rsp_valid_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         prod_ff <= prod_in;
         act1_ff <= act_in;
         trunc_ff <= trunc_in;
         act2_ff <= act1_ff;
         sum_ff <= sum_in;
         act3_ff <= act2_ff;
         out_ff <= out_in;
         sat_ff <= sat_in;
         act4_ff <= act3_ff;
      end
   end

   always_comb begin
      clip_seen = 1'b0;
      for (int i = 0; i < LANES; i++) begin
         if (act4_ff[i] && (out_ff[i] == SAT_MAX || out_ff[i] == SAT_MIN)) begin
            clip_seen = 1'b1;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_x = out_ff[0];
   assign rsp_out_y = out_ff[1];
   assign rsp_out_z = out_ff[2];
   assign rsp_out_w = out_ff[W_LANE];
   assign rsp_saturated = sat_ff;

   a_idle_lane_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !act4_ff[W_LANE]) |-> (out_ff[W_LANE] == '0))
      else $error("inactive w lane not zero");

   a_sat_has_clip: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && sat_ff) |-> clip_seen)
      else $error("saturated flag without clipped lane");

   a_load_no_result: assert property (@(posedge clock) disable iff (reset)
      (pop && (head.op == OP_LOAD_ROW || head.op == OP_IDENTITY)) |=> !v1_ff)
      else $error("matrix update launched a transform");

endmodule

`default_nettype wire

/* rtl/matrix_vector_transform_4x4.sv */
// Top level of the 4x4 Q16.16 matrix transform: front end, queue and back end.
//
//   Channel  Direction  Handshake            Payload
//   req      in         req_valid/req_stall  req_type, req_row_index, req_elem_0..3
//   rsp      out        rsp_valid/rsp_stall  rsp_out_x/y/z/w, rsp_saturated
//
// One item is accepted per cycle while the four-entry queue has room.
// A transform result passes the product, truncate, sum and output registers after its item leaves the queue.
// Row loads and identity update the matrix when they leave the queue.
// Reset clears the matrix to zero and empties the queue and pipeline.
// A stalled result holds the whole back end; the queue then fills and stalls req.
`default_nettype none

module matrix_vector_transform_4x4 import mvt_pkg::*; #(
   parameter int DIM = 4,
   parameter int FRAC_BITS = 16
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_stall,
   input wire logic [1:0] req_type,
   input wire logic [1:0] req_row_index,
   input wire logic signed [ELEM_W-1:0] req_elem_0,
   input wire logic signed [ELEM_W-1:0] req_elem_1,
   input wire logic signed [ELEM_W-1:0] req_elem_2,
   input wire logic signed [ELEM_W-1:0] req_elem_3,
   output logic rsp_valid,
   input wire logic rsp_stall,
   output logic signed [ELEM_W-1:0] rsp_out_x,
   output logic signed [ELEM_W-1:0] rsp_out_y,
   output logic signed [ELEM_W-1:0] rsp_out_z,
   output logic signed [ELEM_W-1:0] rsp_out_w,
   output logic rsp_saturated
);

   q_stat_type qstat;
   q_entry_type entry;
   q_entry_type head;
   logic push;
   logic pop;

   mvt_front #(
      .DIM(DIM)
   ) u_front (
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_type(req_type),
      .req_row_index(req_row_index),
      .req_elem_0(req_elem_0),
      .req_elem_1(req_elem_1),
      .req_elem_2(req_elem_2),
      .req_elem_3(req_elem_3),
      .qstat(qstat),
      .push(push),
      .entry(entry)
   );

   mvt_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .entry(entry),
      .pop(pop),
      .head(head),
      .qstat(qstat)
   );

   mvt_back #(
      .DIM(DIM),
      .FRAC_BITS(FRAC_BITS)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .head(head),
      .qstat(qstat),
      .pop(pop),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_out_x(rsp_out_x),
      .rsp_out_y(rsp_out_y),
      .rsp_out_z(rsp_out_z),
      .rsp_out_w(rsp_out_w),
      .rsp_saturated(rsp_saturated)
   );

endmodule

`default_nettype wire
